// File: sv/lrgs_pkg.sv
package lrgs_pkg;

  // Default capacity of the point memory.
  localparam int MAX_POINTS_DEF = 128;

  // Field and register widths.
  localparam int PT_W       = 16;
  localparam int STEP_W     = 24;
  localparam int CNT_W      = 10;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int SUM_W      = 64;
  localparam int HALF_W     = 48;

  // Datapath widths. Grid values are index times step, below 2^34.
  localparam int T_W     = 34;
  localparam int PROD_W  = T_W + PT_W;
  localparam int A_W     = T_W + 5;
  localparam int DIFF_W  = PROD_W + 2;
  localparam int FRAC_W  = 16;
  localparam int Q_W     = DIFF_W - FRAC_W;
  localparam int ROOT_W  = 32;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // Reset values of the configuration registers.
  localparam logic [STEP_W-1:0] INTERCEPT_STEP_RST  = 24'd629146;
  localparam logic [STEP_W-1:0] SLOPE_STEP_RST      = 24'd39322;
  localparam logic [CNT_W-1:0]  INTERCEPT_COUNT_RST = 10'd250;
  localparam logic [CNT_W-1:0]  SLOPE_COUNT_RST     = 10'd30;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERCEPT_STEP  = 8'd0,
    REG_SLOPE_STEP      = 8'd1,
    REG_INTERCEPT_COUNT = 8'd2,
    REG_SLOPE_COUNT     = 8'd3
  } reg_idx_t;

  // Microprogram addresses.
  typedef enum logic [3:0] {
    S_IDLE    = 4'd0,
    S_INIT    = 4'd1,
    S_ROW     = 4'd2,
    S_LINE    = 4'd3,
    S_STREAM  = 4'd4,
    S_DRAIN   = 4'd5,
    S_CMP     = 4'd6,
    S_NEXTJ   = 4'd7,
    S_DIV     = 4'd8,
    S_DIVWAIT = 4'd9,
    S_OUTWAIT = 4'd10,
    S_OUT     = 4'd11
  } step_t;

  // Jump conditions. A step jumps to its target when its condition holds.
  typedef enum logic [3:0] {
    C_NEVER       = 4'd0,
    C_ALWAYS      = 4'd1,
    C_WAIT_START  = 4'd2,
    C_MORE_K      = 4'd3,
    C_PIPE_BUSY   = 4'd4,
    C_MORE_I      = 4'd5,
    C_MORE_J      = 4'd6,
    C_DIV_BUSY    = 4'd7,
    C_OUT_BLOCKED = 4'd8
  } cond_t;

  // Datapath actions of one control word.
  typedef struct packed {
    logic accept;
    logic init_grid;
    logic init_row;
    logic init_line;
    logic issue;
    logic cmp_step;
    logic next_j;
    logic div_start;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    ctrl_t act;
  } uop_t;

  // Loop status from the datapath.
  typedef struct packed {
    logic more_k;
    logic pipe_busy;
    logic more_i;
    logic more_j;
  } dp_stat_t;

  // Everything the sequencer can branch on.
  typedef struct packed {
    logic     start;
    dp_stat_t dp;
    logic     div_busy;
    logic     out_blocked;
  } status_t;

  // The microprogram.
  function automatic uop_t uop_rom(input step_t s);
    uop_t u;
    u = '0;
    case (s)
      S_IDLE: begin
        u.act.accept = 1'b1;
        u.cond       = C_WAIT_START;
        u.target     = S_IDLE;
      end
      S_INIT: begin
        u.act.init_grid = 1'b1;
      end
      S_ROW: begin
        u.act.init_row = 1'b1;
      end
      S_LINE: begin
        u.act.init_line = 1'b1;
      end
      S_STREAM: begin
        u.act.issue = 1'b1;
        u.cond      = C_MORE_K;
        u.target    = S_STREAM;
      end
      S_DRAIN: begin
        u.cond   = C_PIPE_BUSY;
        u.target = S_DRAIN;
      end
      S_CMP: begin
        u.act.cmp_step = 1'b1;
        u.cond         = C_MORE_I;
        u.target       = S_LINE;
      end
      S_NEXTJ: begin
        u.act.next_j = 1'b1;
        u.cond       = C_MORE_J;
        u.target     = S_ROW;
      end
      S_DIV: begin
        u.act.div_start = 1'b1;
      end
      S_DIVWAIT: begin
        u.cond   = C_DIV_BUSY;
        u.target = S_DIVWAIT;
      end
      S_OUTWAIT: begin
        u.cond   = C_OUT_BLOCKED;
        u.target = S_OUTWAIT;
      end
      S_OUT: begin
        u.act.out_load = 1'b1;
        u.cond         = C_ALWAYS;
        u.target       = S_IDLE;
      end
      default: begin
        u.cond   = C_ALWAYS;
        u.target = S_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

// File: sv/linreg_grid_search_mse.sv
// Points load at one per cycle while the sequencer sits in its idle step. The final
// point starts a search that a microcoded sequencer runs over the grid, paced by the
// single squared-error pipeline reading one stored point per cycle, then runs the
// bit-serial division and output. One search runs at a time.
// Synchronous reset clears control state and restores the default grid registers;
// the point memory is not cleared and needs no clearing pass.
module linreg_grid_search_mse #(
  parameter int MAX_POINTS = lrgs_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            point_valid,
  output logic                            point_stall,
  input  logic [lrgs_pkg::PT_W-1:0]       point_x,
  input  logic [lrgs_pkg::PT_W-1:0]       point_y,
  input  logic                            last_point,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [lrgs_pkg::CNT_W-1:0]      best_intercept_index,
  output logic [lrgs_pkg::CNT_W-1:0]      best_slope_index,
  output logic [lrgs_pkg::HALF_W-1:0]     min_half_mse,
  output logic                            points_dropped,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lrgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrgs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int VW = CW + 1;

  logic [lrgs_pkg::STEP_W-1:0] intercept_step;
  logic [lrgs_pkg::STEP_W-1:0] slope_step;
  logic [lrgs_pkg::CNT_W-1:0]  intercept_count;
  logic [lrgs_pkg::CNT_W-1:0]  slope_count;

  lrgs_pkg::ctrl_t    ctrl;
  lrgs_pkg::status_t  status;
  lrgs_pkg::dp_stat_t dp_stat;

  logic                        point_xfer;
  logic [lrgs_pkg::SUM_W-1:0]  best;
  logic [lrgs_pkg::CNT_W-1:0]  best_i;
  logic [lrgs_pkg::CNT_W-1:0]  best_j;
  logic [CW-1:0]               count;
  logic                        overflow;
  logic                        div_busy;
  logic [lrgs_pkg::SUM_W-1:0]  quotient;

  // Points are taken only while the sequencer sits in its idle step. A finished
  // result may still be waiting in the output register while the next batch loads.
  assign point_stall = !ctrl.accept;
  assign point_xfer  = point_valid && ctrl.accept;

  // Configuration writes are always taken. The sender must issue them only while no
  // search or result is in flight, since a write lands at once; the block does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      intercept_step  <= lrgs_pkg::INTERCEPT_STEP_RST;
      slope_step      <= lrgs_pkg::SLOPE_STEP_RST;
      intercept_count <= lrgs_pkg::INTERCEPT_COUNT_RST;
      slope_count     <= lrgs_pkg::SLOPE_COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lrgs_pkg::REG_INTERCEPT_STEP:  intercept_step  <= cfg_data[lrgs_pkg::STEP_W-1:0];
        lrgs_pkg::REG_SLOPE_STEP:      slope_step      <= cfg_data[lrgs_pkg::STEP_W-1:0];
        lrgs_pkg::REG_INTERCEPT_COUNT: intercept_count <= cfg_data[lrgs_pkg::CNT_W-1:0];
        lrgs_pkg::REG_SLOPE_COUNT:     slope_count     <= cfg_data[lrgs_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The final point of a batch is written, unless the memory is full, and starts the search at the same edge.
  assign status.start       = point_xfer && last_point;
  assign status.dp          = dp_stat;
  assign status.div_busy    = div_busy;
  assign status.out_blocked = result_valid && result_stall;

  lrgs_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  lrgs_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .wr_en           (point_xfer),
    .wr_x            (point_x),
    .wr_y            (point_y),
    .intercept_step  (intercept_step),
    .slope_step      (slope_step),
    .intercept_count (intercept_count),
    .slope_count     (slope_count),
    .stat            (dp_stat),
    .best            (best),
    .best_i          (best_i),
    .best_j          (best_j),
    .count           (count),
    .overflow        (overflow)
  );

  // The least sum is divided by twice the point count. The count is never zero
  // here, because the final point is either stored or finds the memory full.
  lrgs_div #(
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (best),
    .divisor  ({count, 1'b0}),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // The output register holds the result until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      best_intercept_index <= best_i;
      best_slope_index     <= best_j;
      points_dropped       <= overflow;
      if (|quotient[lrgs_pkg::SUM_W-1:lrgs_pkg::HALF_W]) begin
        min_half_mse <= '1;
      end else begin
        min_half_mse <= quotient[lrgs_pkg::HALF_W-1:0];
      end
    end
  end

endmodule

// File: sv/lrgs_seq.sv
module lrgs_seq (
  input  logic              clk,
  input  logic              rst,
  input  lrgs_pkg::status_t status,
  output lrgs_pkg::ctrl_t   ctrl
);

  lrgs_pkg::step_t step;
  lrgs_pkg::step_t step_next;
  lrgs_pkg::uop_t  uop;
  logic            take;

  assign uop  = lrgs_pkg::uop_rom(step);
  assign ctrl = uop.act;

  always_comb begin
    case (uop.cond)
      lrgs_pkg::C_NEVER:       take = 1'b0;
      lrgs_pkg::C_ALWAYS:      take = 1'b1;
      lrgs_pkg::C_WAIT_START:  take = !status.start;
      lrgs_pkg::C_MORE_K:      take = status.dp.more_k;
      lrgs_pkg::C_PIPE_BUSY:   take = status.dp.pipe_busy;
      lrgs_pkg::C_MORE_I:      take = status.dp.more_i;
      lrgs_pkg::C_MORE_J:      take = status.dp.more_j;
      lrgs_pkg::C_DIV_BUSY:    take = status.div_busy;
      lrgs_pkg::C_OUT_BLOCKED: take = status.out_blocked;
      default:                 take = 1'b1;
    endcase
    step_next = take ? uop.target : lrgs_pkg::step_t'(step + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= lrgs_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// File: sv/lrgs_div.sv
module lrgs_div #(
  parameter int VW = 9
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lrgs_pkg::SUM_W-1:0] dividend,
  input  logic [VW-1:0]              divisor,
  output logic                       busy,
  output logic [lrgs_pkg::SUM_W-1:0] quotient
);

  // Restoring division, one quotient bit per cycle.
  logic [lrgs_pkg::DIV_CNT_W-1:0] cnt;
  logic [VW-1:0]                  rem;
  logic [VW-1:0]                  dsr;
  logic [lrgs_pkg::SUM_W-1:0]     quo;
  logic [VW:0]                    trial;
  logic [VW:0]                    trial_sub;
  logic                           ge;

  assign trial     = {rem, quo[lrgs_pkg::SUM_W-1]};
  assign ge        = trial >= {1'b0, dsr};
  assign trial_sub = trial - {1'b0, dsr};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= lrgs_pkg::DIV_CNT_W'(lrgs_pkg::SUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == lrgs_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[lrgs_pkg::SUM_W-2:0], ge};
      rem <= ge ? trial_sub[VW-1:0] : trial[VW-1:0];
    end
  end

endmodule

// File: sv/lrgs_dp.sv
module lrgs_dp #(
  parameter int MAX_POINTS = lrgs_pkg::MAX_POINTS_DEF,
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lrgs_pkg::ctrl_t             ctrl,
  input  logic                        wr_en,
  input  logic [lrgs_pkg::PT_W-1:0]   wr_x,
  input  logic [lrgs_pkg::PT_W-1:0]   wr_y,
  input  logic [lrgs_pkg::STEP_W-1:0] intercept_step,
  input  logic [lrgs_pkg::STEP_W-1:0] slope_step,
  input  logic [lrgs_pkg::CNT_W-1:0]  intercept_count,
  input  logic [lrgs_pkg::CNT_W-1:0]  slope_count,
  output lrgs_pkg::dp_stat_t          stat,
  output logic [lrgs_pkg::SUM_W-1:0]  best,
  output logic [lrgs_pkg::CNT_W-1:0]  best_i,
  output logic [lrgs_pkg::CNT_W-1:0]  best_j,
  output logic [CW-1:0]               count,
  output logic                        overflow
);

  logic [lrgs_pkg::PT_W-1:0] x_mem [MAX_POINTS];
  logic [lrgs_pkg::PT_W-1:0] y_mem [MAX_POINTS];

  logic                         full;
  logic [AW-1:0]                k;
  logic [lrgs_pkg::CNT_W-1:0]   i;
  logic [lrgs_pkg::CNT_W-1:0]   j;
  logic [lrgs_pkg::CNT_W-1:0]   i_last;
  logic [lrgs_pkg::CNT_W-1:0]   j_last;
  logic [lrgs_pkg::T_W-1:0]     t0;
  logic [lrgs_pkg::T_W-1:0]     t1;
  logic [lrgs_pkg::SUM_W-1:0]   sum;

  // Pipeline registers and their valid bits.
  logic                         v_rd, v_mul, v_err, v_mag, v_sq;
  logic [lrgs_pkg::PT_W-1:0]    rd_x;
  logic [lrgs_pkg::PT_W-1:0]    rd_y;
  logic [lrgs_pkg::PROD_W-1:0]  prod;
  logic signed [lrgs_pkg::A_W-1:0]    a;
  logic signed [lrgs_pkg::DIFF_W-1:0] diff;
  logic signed [lrgs_pkg::Q_W-1:0]    q;
  logic [lrgs_pkg::Q_W-1:0]     mag;
  logic [lrgs_pkg::SUM_W-1:0]   sq;
  logic [lrgs_pkg::SUM_W:0]     acc;

  assign full   = count == CW'(MAX_POINTS);
  assign i_last = (intercept_count == '0) ? '0 : intercept_count - 1'b1;
  assign j_last = (slope_count == '0) ? '0 : slope_count - 1'b1;

  assign stat.more_k    = CW'(k) != (count - CW'(1));
  assign stat.more_i    = i != i_last;
  assign stat.more_j    = j != j_last;
  assign stat.pipe_busy = v_rd | v_mul | v_err | v_mag | v_sq;

  // Point memory.
  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      x_mem[count[AW-1:0]] <= wr_x;
      y_mem[count[AW-1:0]] <= wr_y;
    end
    if (ctrl.issue) begin
      rd_x <= x_mem[k];
      rd_y <= y_mem[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (ctrl.out_load) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (wr_en) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  // Loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
      i <= '0;
      j <= '0;
    end else begin
      if (ctrl.init_line) begin
        k <= '0;
      end else if (ctrl.issue) begin
        k <= k + 1'b1;
      end
      if (ctrl.init_row) begin
        i <= '0;
      end else if (ctrl.cmp_step) begin
        i <= i + 1'b1;
      end
      if (ctrl.init_grid) begin
        j <= '0;
      end else if (ctrl.next_j) begin
        j <= j + 1'b1;
      end
    end
  end

  // Grid values are stepped by addition instead of multiplied out.
  always_ff @(posedge clk) begin
    if (ctrl.init_row) begin
      t0 <= '0;
    end else if (ctrl.cmp_step) begin
      t0 <= t0 + lrgs_pkg::T_W'(intercept_step);
    end
    if (ctrl.init_grid) begin
      t1 <= '0;
    end else if (ctrl.next_j) begin
      t1 <= t1 + lrgs_pkg::T_W'(slope_step);
    end
    if (ctrl.init_grid) begin
      best   <= '1;
      best_i <= '0;
      best_j <= '0;
    end else if (ctrl.cmp_step && (sum < best)) begin
      best   <= sum;
      best_i <= i;
      best_j <= j;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_rd  <= 1'b0;
      v_mul <= 1'b0;
      v_err <= 1'b0;
      v_mag <= 1'b0;
      v_sq  <= 1'b0;
    end else begin
      v_rd  <= ctrl.issue;
      v_mul <= v_rd;
      v_err <= v_mul;
      v_mag <= v_err;
      v_sq  <= v_mag;
    end
  end

  // The error is floored to Q.4 by keeping the high bits of the Q.20 difference.
  assign diff = {{(lrgs_pkg::DIFF_W - lrgs_pkg::A_W){a[lrgs_pkg::A_W-1]}}, a}
              - lrgs_pkg::DIFF_W'(prod);
  assign acc  = {1'b0, sum} + {1'b0, sq};

  always_ff @(posedge clk) begin
    prod <= lrgs_pkg::PROD_W'(t1) * lrgs_pkg::PROD_W'(rd_x);
    a    <= lrgs_pkg::A_W'({rd_y, 16'b0}) - lrgs_pkg::A_W'({t0, 4'b0});
    q    <= diff[lrgs_pkg::DIFF_W-1:lrgs_pkg::FRAC_W];
    mag  <= q[lrgs_pkg::Q_W-1] ? lrgs_pkg::Q_W'(-q) : lrgs_pkg::Q_W'(q);
    if (|mag[lrgs_pkg::Q_W-1:lrgs_pkg::ROOT_W]) begin
      sq <= '1;
    end else begin
      sq <= lrgs_pkg::SUM_W'(mag[lrgs_pkg::ROOT_W-1:0])
          * lrgs_pkg::SUM_W'(mag[lrgs_pkg::ROOT_W-1:0]);
    end
    if (ctrl.init_line) begin
      sum <= '0;
    end else if (v_sq) begin
      sum <= acc[lrgs_pkg::SUM_W] ? '1 : acc[lrgs_pkg::SUM_W-1:0];
    end
  end

endmodule

// File: test/linreg_grid_search_mse_test.sv
`timescale 1ns / 1ps

module linreg_grid_search_mse_test;
  import lrgs_pkg::*;

  // Saturation limits of the squared-error sum and of the reported half MSE.
  localparam logic [SUM_W-1:0]  SUM_SAT  = '1;
  localparam logic [HALF_W-1:0] HALF_SAT = '1;

  // An index that selects no register. A write to it must leave the grid alone.
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_IDX = 8'hFF;

  // Length of the one long hold-off on the result side, in clock cycles.
  localparam int unsigned HOLD_CYCLES = 4000;

  // One fit as the block reports it.
  typedef struct packed {
    logic [CNT_W-1:0]  icpt_idx;
    logic [CNT_W-1:0]  slope_idx;
    logic [HALF_W-1:0] half_mse;
    logic              dropped;
  } fit_t;

  // The scoreboard keeps its own copy of the point memory and of the grid
  // registers. When the final point of a batch is accepted it runs the full grid
  // search itself and queues the fit that the block must report.
  class grid_fit_board;
    logic [PT_W-1:0]   xs [MAX_POINTS_DEF];
    logic [PT_W-1:0]   ys [MAX_POINTS_DEF];
    int unsigned       n_pts;
    bit                overflow;
    logic [STEP_W-1:0] icpt_step;
    logic [STEP_W-1:0] slope_step;
    logic [CNT_W-1:0]  icpt_cnt;
    logic [CNT_W-1:0]  slope_cnt;
    fit_t              fits_due [$];
    int unsigned       errors;

    function new();
      n_pts      = 0;
      overflow   = 1'b0;
      icpt_step  = INTERCEPT_STEP_RST;
      slope_step = SLOPE_STEP_RST;
      icpt_cnt   = INTERCEPT_COUNT_RST;
      slope_cnt  = SLOPE_COUNT_RST;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_INTERCEPT_STEP:  icpt_step  = data[STEP_W-1:0];
        REG_SLOPE_STEP:      slope_step = data[STEP_W-1:0];
        REG_INTERCEPT_COUNT: icpt_cnt   = data[CNT_W-1:0];
        REG_SLOPE_COUNT:     slope_cnt  = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Squared error of one point in Q.8. The error is floored to Q.4 first.
    function logic [SUM_W-1:0] square_err(logic [63:0] y20, logic [63:0] t0,
                                          logic [63:0] t1, logic [PT_W-1:0] x);
      logic [63:0] hyp;
      logic [63:0] mag;
      hyp = t0 + t1 * x;
      if (y20 >= hyp) begin
        mag = (y20 - hyp) >> 16;
      end else begin
        mag = ((hyp - y20) + 64'hFFFF) >> 16;
      end
      if (mag > 64'hFFFF_FFFF) begin
        return SUM_SAT;
      end
      return mag * mag;
    endfunction

    function logic [SUM_W-1:0] line_cost(logic [63:0] t0, logic [63:0] t1);
      logic [SUM_W-1:0] sum;
      logic [SUM_W-1:0] sq;
      sum = '0;
      for (int unsigned k = 0; k < n_pts; k++) begin
        sq  = square_err({32'd0, ys[k], 16'd0}, t0, t1, xs[k]);
        sum = (sum > SUM_SAT - sq) ? SUM_SAT : sum + sq;
      end
      return sum;
    endfunction

    // Slope is the outer loop, intercept the inner one; the first strict minimum wins.
    function fit_t fit_batch();
      fit_t             f;
      logic [SUM_W-1:0] best;
      logic [SUM_W-1:0] cost;
      logic [63:0]      t0;
      logic [63:0]      t1;
      logic [63:0]      half;
      int unsigned      ni;
      int unsigned      nj;
      f    = '0;
      best = SUM_SAT;
      ni   = (icpt_cnt == 0) ? 1 : icpt_cnt;
      nj   = (slope_cnt == 0) ? 1 : slope_cnt;
      for (int unsigned j = 0; j < nj; j++) begin
        t1 = 64'(j) * slope_step;
        for (int unsigned i = 0; i < ni; i++) begin
          t0   = (64'(i) * icpt_step) << 4;
          cost = line_cost(t0, t1);
          if (cost < best) begin
            best        = cost;
            f.icpt_idx  = 10'(i);
            f.slope_idx = 10'(j);
          end
        end
      end
      half = best / (64'd2 * ((n_pts == 0) ? 1 : n_pts));
      f.half_mse = (half > HALF_SAT) ? HALF_SAT : half[HALF_W-1:0];
      f.dropped  = overflow;
      return f;
    endfunction

    function void note_point(logic [PT_W-1:0] x, logic [PT_W-1:0] y, logic last);
      if (n_pts < MAX_POINTS_DEF) begin
        xs[n_pts] = x;
        ys[n_pts] = y;
        n_pts++;
      end else begin
        overflow = 1'b1;
      end
      if (last) begin
        fits_due.push_back(fit_batch());
        n_pts    = 0;
        overflow = 1'b0;
      end
    endfunction

    function void check_fit(fit_t got);
      fit_t want;
      if (fits_due.size() == 0) begin
        $error("fit reported with none expected: intercept %0d slope %0d",
               got.icpt_idx, got.slope_idx);
        errors++;
        return;
      end
      want = fits_due.pop_front();
      if (got.icpt_idx !== want.icpt_idx) begin
        $error("best_intercept_index: expected %0d, got %0d", want.icpt_idx, got.icpt_idx);
        errors++;
      end
      if (got.slope_idx !== want.slope_idx) begin
        $error("best_slope_index: expected %0d, got %0d", want.slope_idx, got.slope_idx);
        errors++;
      end
      if (got.half_mse !== want.half_mse) begin
        $error("min_half_mse: expected %0h, got %0h", want.half_mse, got.half_mse);
        errors++;
      end
      if (got.dropped !== want.dropped) begin
        $error("points_dropped: expected %0b, got %0b", want.dropped, got.dropped);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return fits_due.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  point_valid;
  logic                  point_stall;
  logic [PT_W-1:0]       point_x;
  logic [PT_W-1:0]       point_y;
  logic                  last_point;
  logic                  result_valid;
  logic                  result_stall;
  logic [CNT_W-1:0]      best_intercept_index;
  logic [CNT_W-1:0]      best_slope_index;
  logic [HALF_W-1:0]     min_half_mse;
  logic                  points_dropped;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  grid_fit_board board = new();

  // While steady is set neither side idles. hold_req asks the result side for
  // its one long hold-off; that side clears it once it has started counting.
  bit          steady;
  bit          hold_req;
  int unsigned items_sent;

  linreg_grid_search_mse #(
    .MAX_POINTS(MAX_POINTS_DEF)
  ) DUT (
    .*
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A generous ceiling on the whole run. The slowest legal run, with the default
  // 250 by 30 grid for the first batch and every stall at its longest, is well
  // under a tenth of this.
  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  // Offer one point and wait until its transfer completes. The sender may first
  // idle at random. Valid is left high so that a following point goes out
  // back to back; settle() lowers it when the sender has nothing more to offer.
  task automatic send_point(logic [PT_W-1:0] x, logic [PT_W-1:0] y, logic last);
    while (!steady && $urandom_range(99) < 16) begin
      point_valid <= 1'b0;
      @(posedge clk);
    end
    point_valid <= 1'b1;
    point_x     <= x;
    point_y     <= y;
    last_point  <= last;
    @(posedge clk);
    while (point_stall) begin
      @(posedge clk);
    end
    board.note_point(x, y, last);
  endtask

  // Send one batch. Most batches lie close to a line with small noise, so the best
  // fit tends to land inside the grid. The rest, and a tenth of the points of the
  // tidy batches, use the full range of both fields.
  task automatic send_batch(int unsigned len);
    logic [PT_W-1:0] base;
    logic [PT_W-1:0] x;
    logic [PT_W-1:0] y;
    logic [7:0]      slope;
    bit              tidy;
    tidy  = $urandom_range(99) < 70;
    base  = PT_W'($urandom_range(0, 4095));
    slope = 8'($urandom_range(0, 64));
    for (int unsigned k = 0; k < len; k++) begin
      if (tidy && $urandom_range(9) != 0) begin
        x = PT_W'($urandom_range(0, 4095));
        y = base + 16'((32'(x) * slope) >> 4) + 16'($urandom_range(0, 63));
      end else begin
        x = PT_W'($urandom);
        y = PT_W'($urandom);
      end
      send_point(x, y, k == len - 1);
      items_sent++;
    end
  endtask

  // Stop offering points and wait until every expected fit has come out. The
  // extra cycles let the sequencer return to its idle step before any write.
  task automatic settle();
    point_valid <= 1'b0;
    while (board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    board.set_reg(idx, data);
  endtask

  // Write the whole grid, plus one write to an index that holds no register.
  // The data words may carry stray bits above each register's width.
  task automatic program_grid(logic [CFG_DATA_W-1:0] icpt_step,
                              logic [CFG_DATA_W-1:0] slope_step,
                              logic [CFG_DATA_W-1:0] icpt_cnt,
                              logic [CFG_DATA_W-1:0] slope_cnt);
    write_reg(REG_INTERCEPT_STEP, icpt_step);
    write_reg(SPARE_REG_IDX, $urandom);
    write_reg(REG_SLOPE_STEP, slope_step);
    write_reg(REG_INTERCEPT_COUNT, icpt_cnt);
    write_reg(REG_SLOPE_COUNT, slope_cnt);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_step();
    int unsigned       r;
    logic [STEP_W-1:0] step;
    r = $urandom_range(99);
    if (r < 10) begin
      step = '0;
    end else if (r < 20) begin
      step = '1;
    end else if (r < 55) begin
      step = STEP_W'($urandom);
    end else begin
      step = STEP_W'($urandom_range(0, 1 << 17));
    end
    return {8'($urandom), step};
  endfunction

  // A count of zero searches index 0 only, so it shows up now and then.
  function automatic logic [CFG_DATA_W-1:0] pick_count(int unsigned lo, int unsigned hi);
    logic [CNT_W-1:0] cnt;
    if (lo <= 1 && $urandom_range(9) == 0) begin
      cnt = '0;
    end else begin
      cnt = CNT_W'($urandom_range(lo, hi));
    end
    return {22'($urandom), cnt};
  endfunction

  // Result side. A fit is taken at each edge where valid is high and stall low.
  // Stall is drawn at random, except for one long hold-off that lets the block
  // fill up and push back on its point input.
  initial begin : result_side
    int unsigned hold_left;
    hold_left = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        board.check_fit({best_intercept_index, best_slope_index, min_half_mse,
                         points_dropped});
      end
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !steady && ($urandom_range(99) < 16);
      end
    end
  end

  initial begin : stimulus
    int unsigned     phase_no;
    int unsigned     batches;
    int unsigned     len;
    bit              wide;
    logic [CFG_DATA_W-1:0] icpt_cnt;
    logic [CFG_DATA_W-1:0] slope_cnt;
    rst         <= 1'b1;
    point_valid <= 1'b0;
    point_x     <= '0;
    point_y     <= '0;
    last_point  <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_INTERCEPT_STEP;
    cfg_data    <= '0;
    steady      = 1'b0;
    hold_req    = 1'b0;
    items_sent  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The registers still hold their reset values, so this batch is searched
    // over the default 250 by 30 grid. It holds both corners of the point range.
    send_point(16'h0000, 16'h0000, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 1'b0);
    send_point(16'h1234, 16'h5678, 1'b1);
    settle();

    // Zero intercept step and count, largest slope step and count. Lines with a
    // large slope index miss the first point by more than the error range, so
    // their squared error saturates.
    program_grid(32'h5A00_0000, 32'h00FF_FFFF, 32'hFFFF_FC00, 32'h8000_07FF);
    send_point(16'hFFFF, 16'h0000, 1'b1);
    send_point(16'h0000, 16'hFFFF, 1'b1);
    settle();

    // Largest intercept step and count, zero slope step and count.
    program_grid(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_03FF, 32'h0000_0000);
    send_point(16'h0010, 16'hFFFF, 1'b0);
    send_point(16'hFFF0, 16'h0001, 1'b1);
    settle();

    // Intercept step 1.0 and slope step 0.5 over 16 by 8 lines. The first four
    // points lie on y = 3 + 0.5x; the last one sits a fraction above it, so the
    // fit is exact at intercept index 3, slope index 1 except for the floored error.
    program_grid(32'h0001_0000, 32'h0000_8000, 32'd16, 32'd8);
    send_point(16'd0, 16'd48, 1'b0);
    send_point(16'd32, 16'd64, 1'b0);
    send_point(16'd64, 16'd80, 1'b0);
    send_point(16'd96, 16'd96, 1'b0);
    send_point(16'd160, 16'd135, 1'b1);
    settle();

    // Random phases. Each phase sets a new grid and sends a few batches. Most
    // grids are small so the search stays short; every eighth phase widens one
    // axis and keeps its batches short. The first phase fills the point memory
    // exactly, then overruns it so that the last points, the final one among
    // them, are dropped.
    phase_no = 0;
    while (items_sent < 1900) begin
      wide = (phase_no % 8 == 6);
      if (wide) begin
        icpt_cnt  = pick_count(9, 64);
        slope_cnt = pick_count(1, 4);
        if ($urandom_range(1) == 0) begin
          {icpt_cnt, slope_cnt} = {slope_cnt, icpt_cnt};
        end
      end else begin
        icpt_cnt  = pick_count(1, 8);
        slope_cnt = pick_count(1, 8);
      end
      program_grid(pick_step(), pick_step(), icpt_cnt, slope_cnt);
      steady = (phase_no == 4);
      if (phase_no == 2) begin
        hold_req = 1'b1;
      end
      batches = $urandom_range(3, 10);
      for (int unsigned b = 0; b < batches; b++) begin
        if (phase_no == 0 && b == 0) begin
          len = MAX_POINTS_DEF;
        end else if (phase_no == 0 && b == 1) begin
          len = MAX_POINTS_DEF + 3;
        end else if (!wide && $urandom_range(99) < 2) begin
          len = $urandom_range(MAX_POINTS_DEF - 8, MAX_POINTS_DEF + 12);
        end else if (wide) begin
          len = $urandom_range(1, 4);
        end else begin
          len = $urandom_range(1, 20);
        end
        send_batch(len);
      end
      settle();
      steady = 1'b0;
      phase_no++;
    end

    // settle() has already waited for the last fit; give the block a little more
    // time so that any stray transfer would still be caught.
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
